### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the priority class bit enumerator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/pcbe_pkg.sv
// Package for the priority class bit enumerator: widths, register reset
// values and configuration register indexes. No dependencies.
package pcbe_pkg;

    localparam int DATA_W         = 64;
    localparam int TOTAL_W        = 7;
    localparam int BOARD_BITS_DEF = 64;
    localparam int CFG_IDX_W      = 2;

    localparam logic [DATA_W-1:0] CLASS_A_RST = 64'h8100_0000_0000_0081;
    localparam logic [DATA_W-1:0] CLASS_B_RST = 64'h0;
    localparam logic [DATA_W-1:0] CLASS_C_RST = 64'h0;
    localparam logic [DATA_W-1:0] PASS_RST    = 64'h0;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS    = 2'd3;

endpackage

### hdl/pcbe_pick.sv
// Pick unit: lowest remaining candidate of the highest-priority
// nonempty class group. Depends on pcbe_pkg for the default board size.
module pcbe_pick #(
    parameter int BOARD_BITS = pcbe_pkg::BOARD_BITS_DEF
) (
    input  logic [BOARD_BITS-1:0] cand,
    input  logic [BOARD_BITS-1:0] class_a,
    input  logic [BOARD_BITS-1:0] class_b,
    input  logic [BOARD_BITS-1:0] class_c,
    output logic [BOARD_BITS-1:0] low
);

    logic [BOARD_BITS-1:0] grp_a;
    logic [BOARD_BITS-1:0] grp_b;
    logic [BOARD_BITS-1:0] grp_c;
    logic [BOARD_BITS-1:0] grp_r;
    logic [BOARD_BITS-1:0] sel;

    assign grp_a = cand & class_a;
    assign grp_b = cand & class_b & ~class_a;
    assign grp_c = cand & class_c & ~class_a & ~class_b;
    assign grp_r = cand & ~(class_a | class_b | class_c);

    always_comb
    begin
        if (grp_a != '0)
        begin
            sel = grp_a;
        end
        else if (grp_b != '0)
        begin
            sel = grp_b;
        end
        else if (grp_c != '0)
        begin
            sel = grp_c;
        end
        else
        begin
            sel = grp_r;
        end
    end

    assign low = sel & (~sel + BOARD_BITS'(1));

endmodule

### hdl/priority_class_bit_enumerator.sv
// Priority class bit enumerator top level: sequencer, config registers, output regs.
// Depends on pcbe_pkg, pcbe_pick and assert_macros.svh.
// Flow: start loads the masks, ST_CNT registers byte popcounts, ST_SUM registers the total,
// ST_EMIT registers the results; an empty mask gives the pass word from ST_SUM. No stalls; start is taken only in idle.
// busy is high from the start transfer until the last result is registered.
// Reset (rst_n low, async): idle, no strobe, class and pass registers at defaults.
module priority_class_bit_enumerator #(
    parameter int BOARD_BITS = pcbe_pkg::BOARD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pcbe_pkg::DATA_W-1:0]       candidate_mask,
    input  logic [pcbe_pkg::DATA_W-1:0]       hint_move,
    output logic                              strobe,
    output logic [pcbe_pkg::DATA_W-1:0]       move_word,
    output logic [pcbe_pkg::TOTAL_W-1:0]      move_total,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcbe_pkg::DATA_W-1:0]       cfg_data
);

    `include "assert_macros.svh"

    localparam int DW     = pcbe_pkg::DATA_W;
    localparam int TW     = pcbe_pkg::TOTAL_W;
    localparam int NCHUNK = (BOARD_BITS + 7) / 8;
    localparam int PAD_W  = NCHUNK * 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CNT  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 4'(b[i]);
        end
        return c;
    endfunction

    logic [1:0]            state_reg, state_next;
    logic                  strobe_reg, strobe_next;
    logic                  hint_pend_reg, hint_pend_next;
    logic [BOARD_BITS-1:0] cand_reg, cand_next;
    logic [BOARD_BITS-1:0] hint_reg, hint_next;
    logic [3:0]            cnt_reg [NCHUNK];
    logic [3:0]            cnt_next [NCHUNK];
    logic [TW-1:0]         rem_reg, rem_next;
    logic [TW-1:0]         total_reg, total_next;
    logic [DW-1:0]         word_reg, word_next;
    logic                  last_reg, last_next;

    logic [DW-1:0]         class_a_reg;
    logic [DW-1:0]         class_b_reg;
    logic [DW-1:0]         class_c_reg;
    logic [DW-1:0]         pass_reg;

    logic [PAD_W-1:0]      cand_pad;
    logic [TW-1:0]         sum;
    logic [BOARD_BITS-1:0] pick_low;
    logic [BOARD_BITS-1:0] emit_word;
    logic                  hint_ok;

    pcbe_pick #(
        .BOARD_BITS (BOARD_BITS)
    ) u_pick (
        .cand    (cand_reg),
        .class_a (class_a_reg[BOARD_BITS-1:0]),
        .class_b (class_b_reg[BOARD_BITS-1:0]),
        .class_c (class_c_reg[BOARD_BITS-1:0]),
        .low     (pick_low)
    );

    assign cand_pad  = PAD_W'(cand_reg);
    assign hint_ok   = (hint_reg != '0)
                     && ((hint_reg & (hint_reg - BOARD_BITS'(1))) == '0)
                     && ((hint_reg & cand_reg) != '0);
    assign emit_word = hint_pend_reg ? hint_reg : pick_low;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NCHUNK; i++)
        begin
            sum = sum + TW'(cnt_reg[i]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        strobe_next    = 1'b0;
        hint_pend_next = hint_pend_reg;
        cand_next      = cand_reg;
        hint_next      = hint_reg;
        rem_next       = rem_reg;
        total_next     = total_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        for (int i = 0; i < NCHUNK; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cand_next  = candidate_mask[BOARD_BITS-1:0];
                    hint_next  = hint_move[BOARD_BITS-1:0];
                    state_next = ST_CNT;
                end
            end
            ST_CNT:
            begin
                for (int i = 0; i < NCHUNK; i++)
                begin
                    cnt_next[i] = popcount8(cand_pad[i*8 +: 8]);
                end
                hint_pend_next = hint_ok;
                state_next     = ST_SUM;
            end
            ST_SUM:
            begin
                if (sum == '0)
                begin
                    word_next   = pass_reg;
                    total_next  = TW'(1);
                    last_next   = 1'b1;
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rem_next   = sum;
                    total_next = sum;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                word_next      = DW'(emit_word);
                cand_next      = cand_reg & ~emit_word;
                hint_pend_next = 1'b0;
                strobe_next    = 1'b1;
                last_next      = (rem_reg == TW'(1));
                rem_next       = rem_reg - TW'(1);
                if (rem_reg == TW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            strobe_reg    <= 1'b0;
            hint_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            strobe_reg    <= strobe_next;
            hint_pend_reg <= hint_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_next;
        hint_reg  <= hint_next;
        rem_reg   <= rem_next;
        total_reg <= total_next;
        word_reg  <= word_next;
        last_reg  <= last_next;
        for (int i = 0; i < NCHUNK; i++)
        begin
            cnt_reg[i] <= cnt_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_a_reg <= pcbe_pkg::CLASS_A_RST;
            class_b_reg <= pcbe_pkg::CLASS_B_RST;
            class_c_reg <= pcbe_pkg::CLASS_C_RST;
            pass_reg    <= pcbe_pkg::PASS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcbe_pkg::CFG_CLASS_A: class_a_reg <= cfg_data;
                pcbe_pkg::CFG_CLASS_B: class_b_reg <= cfg_data;
                pcbe_pkg::CFG_CLASS_C: class_c_reg <= cfg_data;
                pcbe_pkg::CFG_PASS:    pass_reg    <= cfg_data;
                default:               pass_reg    <= pass_reg;
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign strobe     = strobe_reg;
    assign move_word  = word_reg;
    assign move_total = total_reg;
    assign last       = last_reg;

    // results of one item come in consecutive cycles
    `ASSERT_NEXT(a_burst_contig, clk, rst_n, strobe && !last, strobe)
    `ASSERT_NEXT(a_gap_after_last, clk, rst_n, strobe && last, !strobe)
    `ASSERT_SAME(a_word_onehot, clk, rst_n, strobe && (move_total != TW'(1)), $onehot(move_word))
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)

endmodule
